// ===== hw/rtl/tet_pkg.sv =====
// ---------------------------------------------------------------------------
// Timeout event table package
// Shared types and codes for the one-shot timeout slot table.
// ---------------------------------------------------------------------------
package tet_pkg;

	localparam int unsigned CountW = 32;
	localparam int unsigned TagW   = 16;
	localparam int unsigned IdW    = 8;
	localparam int unsigned KindW  = 3;
	localparam int unsigned SlotW  = 4;
	localparam int unsigned MaxOut = 16;
	localparam int unsigned NumW   = 5;

	typedef enum logic [1:0] {
		ACT_TICK  = 2'd0,
		ACT_REG   = 2'd1,
		ACT_UNREG = 2'd2,
		ACT_NOP   = 2'd3
	} action_t;

	typedef enum logic [KindW-1:0] {
		KIND_REGISTERED   = 3'd0,
		KIND_FULL         = 3'd1,
		KIND_UNREGISTERED = 3'd2,
		KIND_BAD_ID       = 3'd3,
		KIND_FIRED        = 3'd4,
		KIND_NONE         = 3'd5
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_FIN  = 3'b100
	} state_t;

	typedef struct packed {
		logic [CountW-1:0] count;
		logic [TagW-1:0]   tag;
	} slot_entry_t;

endpackage

// ===== hw/rtl/timeout_event_table.sv =====
// ---------------------------------------------------------------------------
// Timeout event table
// Table of one-shot timeout slots walked one slot per cycle unless a stall holds the scan.
// ---------------------------------------------------------------------------
// Input channel s_*: one request per item. s_tuser carries the action (tick,
// register, unregister, idle), s_tdata the duration, handler tag and slot id.
// Output channel m_*: result items, m_tuser the kind, m_tlast on the final
// result of a request.
// Slots live in a single-port-write, single-port-read memory with registered
// read data; one sequencer walks it one slot per cycle, unless a stalled fire
// holds it, through one shared decrement and compare path.
// Idle action: taken with no result, the table stays ready. Unregister: result
// registered as the request is taken. Register: scan of up to NUM_SLOTS slots
// for the lowest free slot, result at its end. Tick: scan of all NUM_SLOTS
// slots, then a closing state that loads the final result once the output
// register is free. Each next request waits until the result has been taken.
// Fired results leave through a one-deep pending register and the output
// register; when the receiver stalls, the scan holds on the next reported
// fire until the output register drains.
// Reset clears the per-slot valid bits at once, so every slot reads as free
// with count and tag zero; no clearing pass runs.
// A new request is taken only in idle with the output register empty.
// ---------------------------------------------------------------------------
module timeout_event_table #(
	parameter int unsigned NUM_SLOTS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,   // duration_ticks[31:0], handler_tag[47:32], slot_id[55:48]
	input  logic [1:0]  s_tuser,   // action[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // slot[3:0], fired_tag[19:4], zero[23:20]
	output logic [2:0]  m_tuser,   // kind[2:0]
	output logic        m_tlast
);

	localparam int unsigned IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam logic [IW-1:0] LastIdx = IW'(NUM_SLOTS - 1);

	tet_pkg::slot_entry_t mem_q [NUM_SLOTS];
	tet_pkg::slot_entry_t rd_q;
	logic [NUM_SLOTS-1:0] vld_q;

	tet_pkg::state_t  st_q;
	tet_pkg::action_t act_q;
	logic [tet_pkg::CountW-1:0] dur_q;
	logic [tet_pkg::TagW-1:0]   tag_q;
	logic [IW-1:0]              idx_q;
	logic [tet_pkg::NumW-1:0]   fire_cnt_q;

	logic                       pend_vld_q;
	logic [IW-1:0]              pend_slot_q;
	logic [tet_pkg::TagW-1:0]   pend_tag_q;

	logic                       out_vld_q;
	tet_pkg::kind_t             out_kind_q;
	logic [tet_pkg::SlotW-1:0]  out_slot_q;
	logic [tet_pkg::TagW-1:0]   out_tag_q;
	logic                       out_last_q;

	logic [tet_pkg::CountW-1:0] in_dur;
	logic [tet_pkg::TagW-1:0]   in_tag;
	logic [tet_pkg::IdW-1:0]    in_id;
	tet_pkg::action_t           in_act;
	logic                       in_take;

	logic                       out_free;
	logic                       out_load;
	logic                       eff_vld;
	logic [tet_pkg::CountW-1:0] eff_cnt;
	logic [tet_pkg::TagW-1:0]   eff_tag;
	logic [tet_pkg::CountW-1:0] dec_cnt;
	logic                       is_free;
	logic                       live;
	logic                       fire;
	logic                       report;
	logic                       stall;
	logic                       at_last;
	logic [IW-1:0]              rd_addr;
	logic                       mem_we;
	tet_pkg::slot_entry_t       mem_wdata;
	logic [IW+3:0]              idx_ext;
	logic [IW+3:0]              pend_ext;
	logic [IW-1:0]              id_idx;
	logic [tet_pkg::IdW+IW-1:0] id_ext;

	assign in_dur  = s_tdata[31:0];
	assign in_tag  = s_tdata[47:32];
	assign in_id   = s_tdata[55:48];
	assign in_act  = tet_pkg::action_t'(s_tuser);
	assign id_ext  = {{IW{1'b0}}, in_id};
	assign id_idx  = id_ext[IW-1:0];

	assign s_tready = (st_q == tet_pkg::ST_IDLE) && !out_vld_q;
	assign in_take  = s_tvalid && s_tready;

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {4'b0000, out_tag_q, out_slot_q};
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;

	assign out_free = !out_vld_q || m_tready;
	assign eff_vld  = vld_q[idx_q];
	assign eff_cnt  = eff_vld ? rd_q.count : '0;
	assign eff_tag  = eff_vld ? rd_q.tag : '0;
	assign dec_cnt  = eff_cnt - 1'b1;
	assign is_free  = (eff_cnt == '0) && (eff_tag == '0);
	assign live     = (eff_cnt != '0);
	assign fire     = live && (dec_cnt == '0) && (eff_tag != '0);
	assign report   = fire && !fire_cnt_q[tet_pkg::NumW-1];
	assign stall    = (act_q == tet_pkg::ACT_TICK) && report && pend_vld_q && !out_free;
	assign at_last  = (idx_q == LastIdx);
	assign idx_ext  = {4'b0000, idx_q};
	assign pend_ext = {4'b0000, pend_slot_q};

	always_comb begin
		out_load = 1'b0;
		unique case (st_q)
			tet_pkg::ST_IDLE: begin
				out_load = in_take && (in_act == tet_pkg::ACT_UNREG);
			end
			tet_pkg::ST_SCAN: begin
				if (act_q == tet_pkg::ACT_REG) begin
					out_load = is_free || at_last;
				end else begin
					out_load = !stall && report && pend_vld_q;
				end
			end
			tet_pkg::ST_FIN: begin
				out_load = out_free;
			end
			default: begin
				out_load = 1'b0;
			end
		endcase
	end

	always_comb begin
		rd_addr   = idx_q;
		mem_we    = 1'b0;
		mem_wdata = '{count: dec_cnt, tag: (fire ? '0 : eff_tag)};
		unique case (st_q)
			tet_pkg::ST_IDLE: begin
				rd_addr = '0;
			end
			tet_pkg::ST_SCAN: begin
				rd_addr = stall ? idx_q : (idx_q + 1'b1);
				if (act_q == tet_pkg::ACT_REG) begin
					mem_we    = is_free;
					mem_wdata = '{count: dur_q, tag: tag_q};
				end else begin
					mem_we = live && !stall;
				end
			end
			tet_pkg::ST_FIN: begin
				rd_addr = idx_q;
			end
			default: begin
				rd_addr = idx_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[idx_q] <= mem_wdata;
		end
		rd_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= tet_pkg::ST_IDLE;
			act_q       <= tet_pkg::ACT_NOP;
			dur_q       <= '0;
			tag_q       <= '0;
			idx_q       <= '0;
			fire_cnt_q  <= '0;
			vld_q       <= '0;
			pend_vld_q  <= 1'b0;
			pend_slot_q <= '0;
			pend_tag_q  <= '0;
			out_vld_q   <= 1'b0;
			out_kind_q  <= tet_pkg::KIND_NONE;
			out_slot_q  <= '0;
			out_tag_q   <= '0;
			out_last_q  <= 1'b0;
		end else begin
			if (out_vld_q && m_tready && !out_load) begin
				out_vld_q <= 1'b0;
			end
			unique case (st_q)
				tet_pkg::ST_IDLE: begin
					if (in_take) begin
						act_q      <= in_act;
						dur_q      <= in_dur;
						tag_q      <= in_tag;
						idx_q      <= '0;
						fire_cnt_q <= '0;
						pend_vld_q <= 1'b0;
						case (in_act) inside
							tet_pkg::ACT_TICK, tet_pkg::ACT_REG: begin
								st_q <= tet_pkg::ST_SCAN;
							end
							tet_pkg::ACT_UNREG: begin
								out_vld_q  <= 1'b1;
								out_slot_q <= '0;
								out_tag_q  <= '0;
								out_last_q <= 1'b1;
								if (in_id < tet_pkg::IdW'(NUM_SLOTS)) begin
									out_kind_q     <= tet_pkg::KIND_UNREGISTERED;
									vld_q[id_idx]  <= 1'b0;
								end else begin
									out_kind_q <= tet_pkg::KIND_BAD_ID;
								end
							end
							default: begin
								st_q <= tet_pkg::ST_IDLE;
							end
						endcase
					end
				end
				tet_pkg::ST_SCAN: begin
					if (act_q == tet_pkg::ACT_REG) begin
						if (is_free) begin
							vld_q[idx_q] <= 1'b1;
							out_vld_q    <= 1'b1;
							out_kind_q   <= tet_pkg::KIND_REGISTERED;
							out_slot_q   <= idx_ext[3:0];
							out_tag_q    <= '0;
							out_last_q   <= 1'b1;
							st_q         <= tet_pkg::ST_IDLE;
						end else if (at_last) begin
							out_vld_q  <= 1'b1;
							out_kind_q <= tet_pkg::KIND_FULL;
							out_slot_q <= '0;
							out_tag_q  <= '0;
							out_last_q <= 1'b1;
							st_q       <= tet_pkg::ST_IDLE;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end else if (!stall) begin
						if (report) begin
							if (pend_vld_q) begin
								out_vld_q  <= 1'b1;
								out_kind_q <= tet_pkg::KIND_FIRED;
								out_slot_q <= pend_ext[3:0];
								out_tag_q  <= pend_tag_q;
								out_last_q <= 1'b0;
							end
							pend_vld_q  <= 1'b1;
							pend_slot_q <= idx_q;
							pend_tag_q  <= eff_tag;
							fire_cnt_q  <= fire_cnt_q + 1'b1;
						end
						if (at_last) begin
							st_q <= tet_pkg::ST_FIN;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				tet_pkg::ST_FIN: begin
					if (out_free) begin
						out_vld_q  <= 1'b1;
						out_last_q <= 1'b1;
						if (pend_vld_q) begin
							out_kind_q <= tet_pkg::KIND_FIRED;
							out_slot_q <= pend_ext[3:0];
							out_tag_q  <= pend_tag_q;
						end else begin
							out_kind_q <= tet_pkg::KIND_NONE;
							out_slot_q <= '0;
							out_tag_q  <= '0;
						end
						pend_vld_q <= 1'b0;
						st_q       <= tet_pkg::ST_IDLE;
					end
				end
				default: begin
					st_q <= tet_pkg::ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== bench/timeout_event_table_tb.sv =====
// ---------------------------------------------------------------------------
// Timeout event table testbench
// Drives tick, register, unregister and idle requests into the slot table
// and checks every result against a scoreboard that keeps its own copy of
// the slot counts and handler tags. Both stream sides idle in random bursts.
// ---------------------------------------------------------------------------
module timeout_event_table_tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned SLOTS = 16;

	class timeout_scoreboard;
		typedef struct {
			tet_pkg::kind_t                 kind;
			logic [tet_pkg::SlotW-1:0]      slot;
			logic [tet_pkg::TagW-1:0]       tag;
			logic                           last;
		} outcome_t;

		logic [tet_pkg::CountW-1:0] ticks_left [SLOTS];
		logic [tet_pkg::TagW-1:0]   handler    [SLOTS];
		outcome_t                   awaited    [$];
		int                         errors;

		function new();
			for (int i = 0; i < SLOTS; i++) begin
				ticks_left[i] = '0;
				handler[i]    = '0;
			end
			errors = 0;
		endfunction

		function void add(tet_pkg::kind_t kind, int slot, logic [tet_pkg::TagW-1:0] tag,
				logic last);
			outcome_t o;
			o.kind = kind;
			o.slot = slot[tet_pkg::SlotW-1:0];
			o.tag  = tag;
			o.last = last;
			awaited.push_back(o);
		endfunction

		function void note_request(tet_pkg::action_t act, logic [tet_pkg::CountW-1:0] dur,
				logic [tet_pkg::TagW-1:0] tag, logic [tet_pkg::IdW-1:0] id);
			int       free_slot;
			outcome_t fires [$];
			outcome_t o;
			case (act)
				tet_pkg::ACT_REG: begin
					free_slot = -1;
					for (int i = SLOTS - 1; i >= 0; i--)
						if (ticks_left[i] == '0 && handler[i] == '0)
							free_slot = i;
					if (free_slot < 0) begin
						add(tet_pkg::KIND_FULL, 0, '0, 1'b1);
					end else begin
						ticks_left[free_slot] = dur;
						handler[free_slot]    = tag;
						add(tet_pkg::KIND_REGISTERED, free_slot, '0, 1'b1);
					end
				end
				tet_pkg::ACT_UNREG: begin
					if (id >= SLOTS) begin
						add(tet_pkg::KIND_BAD_ID, 0, '0, 1'b1);
					end else begin
						ticks_left[id] = '0;
						handler[id]    = '0;
						add(tet_pkg::KIND_UNREGISTERED, 0, '0, 1'b1);
					end
				end
				tet_pkg::ACT_TICK: begin
					for (int i = 0; i < SLOTS; i++) begin
						if (ticks_left[i] != '0) begin
							ticks_left[i] = ticks_left[i] - 1'b1;
							if (ticks_left[i] == '0 && handler[i] != '0) begin
								if (fires.size() < tet_pkg::MaxOut) begin
									o.kind = tet_pkg::KIND_FIRED;
									o.slot = i[tet_pkg::SlotW-1:0];
									o.tag  = handler[i];
									o.last = 1'b0;
									fires.push_back(o);
								end
								handler[i] = '0;
							end
						end
					end
					if (fires.size() == 0) begin
						add(tet_pkg::KIND_NONE, 0, '0, 1'b1);
					end else begin
						fires[fires.size() - 1].last = 1'b1;
						foreach (fires[k])
							awaited.push_back(fires[k]);
					end
				end
				default: begin
				end
			endcase
		endfunction

		function void check_result(logic [tet_pkg::KindW-1:0] kind,
				logic [tet_pkg::SlotW-1:0] slot, logic [tet_pkg::TagW-1:0] tag,
				logic last, logic [3:0] pad);
			outcome_t e;
			if (awaited.size() == 0) begin
				$error("unexpected result: kind %0d slot %0d tag %0h", kind, slot, tag);
				errors++;
				return;
			end
			e = awaited.pop_front();
			if (kind !== e.kind) begin
				$error("kind: expected %0d, got %0d", e.kind, kind);
				errors++;
			end
			if (slot !== e.slot) begin
				$error("slot: expected %0d, got %0d", e.slot, slot);
				errors++;
			end
			if (tag !== e.tag) begin
				$error("fired_tag: expected %0h, got %0h", e.tag, tag);
				errors++;
			end
			if (last !== e.last) begin
				$error("last: expected %0b, got %0b", e.last, last);
				errors++;
			end
			if (pad !== 4'd0) begin
				$error("tdata padding: expected 0, got %0h", pad);
				errors++;
			end
		endfunction

		function int pending();
			return awaited.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [55:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;
	logic [2:0]  m_tuser;
	logic        m_tlast;

	timeout_scoreboard sb;
	bit                quiet;
	int                stall_left;
	int                live_requests;

	timeout_event_table #(
		.NUM_SLOTS(SLOTS)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	task automatic send_request(tet_pkg::action_t act, logic [tet_pkg::CountW-1:0] dur,
			logic [tet_pkg::TagW-1:0] tag, logic [tet_pkg::IdW-1:0] id);
		int gap;
		@(negedge clk);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 17);
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {id, tag, dur};
		s_tuser  <= act;
		do @(posedge clk); while (!s_tready);
		sb.note_request(act, dur, tag, id);
		if (act != tet_pkg::ACT_NOP)
			live_requests++;
	endtask

	function automatic logic [tet_pkg::CountW-1:0] pick_duration();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return $urandom;
			default: return $urandom_range(1, 6);
		endcase
	endfunction

	function automatic logic [tet_pkg::TagW-1:0] pick_tag();
		if ($urandom_range(0, 12) == 0)
			return '0;
		return 16'($urandom_range(1, 65535));
	endfunction

	// receiver: random stall bursts, none once quiet
	initial begin
		m_tready   = 1'b0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (quiet)
				stall_left = 0;
			else if (stall_left == 0 && $urandom_range(0, 7) == 0)
				stall_left = $urandom_range(1, 17);
			if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tuser, m_tdata[3:0], m_tdata[19:4], m_tlast, m_tdata[23:20]);
	end

	initial begin
		#10_000_000;
		$display("Some tests failed");
		$finish;
	end

	initial begin
		int                       burst;
		int                       span;
		logic [tet_pkg::TagW-1:0] t;
		sb            = new();
		quiet         = 1'b0;
		live_requests = 0;
		arst_n        = 1'b0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		s_tuser       = tet_pkg::ACT_TICK;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		send_request(tet_pkg::ACT_TICK,  '0,            '0,       '0);
		send_request(tet_pkg::ACT_REG,   '0,            '0,       8'hFF);
		send_request(tet_pkg::ACT_REG,   '0,            16'hFFFF, '0);
		send_request(tet_pkg::ACT_REG,   32'd3,         '0,       '0);
		send_request(tet_pkg::ACT_REG,   32'd1,         16'h8001, '0);
		send_request(tet_pkg::ACT_REG,   32'hFFFF_FFFF, 16'h1234, '0);
		send_request(tet_pkg::ACT_REG,   32'd2,         16'h00FF, '0);
		send_request(tet_pkg::ACT_REG,   32'd2,         16'hFF00, '0);
		send_request(tet_pkg::ACT_NOP,   $urandom,      16'hA5A5, 8'h5A);
		send_request(tet_pkg::ACT_TICK,  $urandom,      16'hFFFF, 8'hFF);
		send_request(tet_pkg::ACT_TICK,  '0,            '0,       '0);
		send_request(tet_pkg::ACT_TICK,  '0,            '0,       '0);
		send_request(tet_pkg::ACT_UNREG, '0,            '0,       8'd16);
		send_request(tet_pkg::ACT_UNREG, 32'hFFFF_FFFF, 16'hFFFF, 8'd255);
		send_request(tet_pkg::ACT_UNREG, '0,            '0,       8'd1);
		send_request(tet_pkg::ACT_UNREG, '0,            '0,       8'd0);
		send_request(tet_pkg::ACT_UNREG, '0,            '0,       8'd3);
		send_request(tet_pkg::ACT_UNREG, '0,            '0,       8'd15);
		send_request(tet_pkg::ACT_REG,   32'hAAAA_AAAA, 16'h5555, 8'hAA);
		send_request(tet_pkg::ACT_REG,   32'h5555_5555, 16'hAAAA, 8'h55);
		send_request(tet_pkg::ACT_UNREG, '0,            '0,       8'd0);
		send_request(tet_pkg::ACT_UNREG, '0,            '0,       8'd1);

		for (int round = 0; live_requests < 110; round++) begin
			if (live_requests >= 90)
				quiet = 1'b1;
			if (round == 0 || $urandom_range(0, 9) == 0) begin
				// fill many slots with one duration, then tick them down together
				burst = (round == 0) ? 17 : $urandom_range(2, 17);
				span  = $urandom_range(1, 3);
				for (int k = 0; k < burst; k++) begin
					t = ($urandom_range(0, 15) == 0) ? '0 : 16'($urandom_range(1, 65535));
					send_request(tet_pkg::ACT_REG, span, t, 8'($urandom_range(0, 255)));
				end
				repeat (span) send_request(tet_pkg::ACT_TICK, $urandom,
						16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
			end else begin
				case ($urandom_range(0, 19)) inside
					[0:7]:
						send_request(tet_pkg::ACT_TICK, $urandom,
								16'($urandom_range(0, 65535)),
								8'($urandom_range(0, 255)));
					[8:14]:
						send_request(tet_pkg::ACT_REG, pick_duration(), pick_tag(),
								8'($urandom_range(0, 255)));
					[15:17]:
						send_request(tet_pkg::ACT_UNREG, $urandom,
								16'($urandom_range(0, 65535)),
								8'($urandom_range(0, SLOTS - 1)));
					18:
						send_request(tet_pkg::ACT_UNREG, $urandom,
								16'($urandom_range(0, 65535)),
								8'($urandom_range(0, 255)));
					default:
						send_request(tet_pkg::ACT_NOP, $urandom,
								16'($urandom_range(0, 65535)),
								8'($urandom_range(0, 255)));
				endcase
			end
		end

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SLOTS + 8) @(posedge clk);

		if (sb.errors == 0 && sb.pending() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
